>>> hdl/ftc_pkg.sv
package ftc_pkg;

    // Operation codes carried in the input item's tuser.
    typedef enum logic [2:0] {
        OP_JOIN          = 3'd0,
        OP_START         = 3'd1,
        OP_STOP          = 3'd2,
        OP_TICK          = 3'd3,
        OP_END_TURN      = 3'd4,
        OP_ADD_TIME      = 3'd5,
        OP_QUERY_PLAYER  = 3'd6,
        OP_QUERY_CURRENT = 3'd7
    } op_t;

    // Status codes returned with every result item.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_UNKNOWN = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    // Sequencer states: accept, read-modify-write, re-read, deliver.
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_MODIFY = 2'd1,
        S_FETCH  = 2'd2,
        S_RESULT = 2'd3
    } state_t;

    // One slot of the balance memory.
    typedef struct packed {
        logic signed [31:0] remaining;
        logic [23:0]        increment;
    } slot_t;

    localparam int ID_W     = 8;
    localparam int AMOUNT_W = 31;
    localparam int INCR_W   = 24;

endpackage

>>> hdl/ftc_mem.sv
module ftc_mem
    import ftc_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output slot_t         rd_data
);

    slot_t mem_array [DEPTH];
    slot_t rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds between reads.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/ftc_ids.sv
module ftc_ids
    import ftc_pkg::*;
#(
    parameter int MAX_PLAYERS = 4,
    parameter int SLOT_W      = 2,
    parameter int CNT_W       = 3
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_slot,
    input  logic [ID_W-1:0]   wr_id,
    input  logic [CNT_W-1:0]  joined_count,
    input  logic [ID_W-1:0]   lookup_id,
    input  logic [SLOT_W-1:0] turn_slot,
    output logic              hit,
    output logic [SLOT_W-1:0] hit_slot,
    output logic [ID_W-1:0]   turn_id
);

    logic [ID_W-1:0] ids_reg [MAX_PLAYERS];

    // Player ids are written once, on join.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ids_reg[wr_slot] <= wr_id;
        end
    end

    // Compare all occupied slots in parallel; the lowest match wins.
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = MAX_PLAYERS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < joined_count) && (ids_reg[i] == lookup_id)) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign turn_id = ids_reg[turn_slot];

endmodule

>>> hdl/fischer_increment_turn_clock_top.sv
// Multi-player turn clock with Fischer increment.
// Input channel (s_): tuser carries the operation code, tdata the player id,
// a time amount and a per-move increment. Every input item yields exactly one
// result item on the output channel (m_): status in tuser, and in tdata the
// id of the player to move, a valid flag, a remaining balance, the running
// flag and the number of joined players.
// Each item passes through the sequencer steps in order: the accepting cycle
// issues a read of the slot memory, the modify step modifies and writes back
// the slot, the fetch step reads the slot to report, and the result step loads
// the output register. The single read port of the slot memory sets this order,
// so a new item is taken only once the last one has loaded its result.
// Reset clears the player count, the turn pointer, the running flag and the
// output valid; the slot contents stay undefined until players join.
// When the receiver stalls, the finished result waits in the output register
// and the block may still accept and process the next item, which then holds
// in its last step until the output register is free.
module fischer_increment_turn_clock_top
    import ftc_pkg::*;
#(
    parameter int MAX_PLAYERS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] player_id, [38:8] time_amount, [62:39] increment_amount, [63] zero
    input  logic [63:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] to_move_id, [8] to_move_valid, [40:9] remaining_time,
    // [41] is_running, [44:42] players_joined, [47:45] zero
    output logic [47:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);

    localparam int SLOT_W = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
    localparam int CNT_W  = $clog2(MAX_PLAYERS + 1);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Input field views.
    op_t                 op_in;
    logic [ID_W-1:0]     id_in;
    logic [AMOUNT_W-1:0] amount_in;
    logic [INCR_W-1:0]   incr_in;

    assign op_in     = op_t'(s_tuser);
    assign id_in     = s_tdata[7:0];
    assign amount_in = s_tdata[38:8];
    assign incr_in   = s_tdata[62:39];

    // Control state.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    joined_reg, joined_next;
    logic [SLOT_W-1:0]   turn_reg, turn_next;
    logic                running_reg, running_next;

    // Item registers.
    op_t                 op_reg;
    status_t             status_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ID_W-1:0]     id_reg;
    logic [AMOUNT_W-1:0] amount_reg;
    logic [INCR_W-1:0]   incr_reg;

    // Output register.
    logic                m_tvalid_reg;
    logic [47:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic                accept;
    logic                out_load;
    logic                mem_re;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_raddr;
    logic [SLOT_W-1:0]   mem_waddr;
    slot_t               mem_wdata;
    slot_t               mem_rdata;
    logic                ids_we;
    logic                hit;
    logic [SLOT_W-1:0]   hit_slot;
    logic [ID_W-1:0]     turn_id;
    status_t             status_in;
    logic                any_player;

    // Saturating add of a non-negative amount to a signed balance.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic [AMOUNT_W-1:0] b);
        logic [32:0] sum;
        sum = {a[31], a} + {2'b00, b};
        if (sum[32] != sum[31]) begin
            sat_add = S32_MAX;
        end else begin
            sat_add = sum[31:0];
        end
    endfunction

    ftc_ids #(
        .MAX_PLAYERS (MAX_PLAYERS),
        .SLOT_W      (SLOT_W),
        .CNT_W       (CNT_W)
    ) u_ids (
        .aclk         (aclk),
        .wr_en        (ids_we),
        .wr_slot      (mem_waddr),
        .wr_id        (id_reg),
        .joined_count (joined_reg),
        .lookup_id    (id_in),
        .turn_slot    (turn_reg),
        .hit          (hit),
        .hit_slot     (hit_slot),
        .turn_id      (turn_id)
    );

    ftc_mem #(
        .DEPTH (MAX_PLAYERS),
        .AW    (SLOT_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign any_player = (joined_reg != '0);

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_MODIFY;
            S_MODIFY: state_next = S_FETCH;
            S_FETCH:  state_next = S_RESULT;
            S_RESULT: if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                mem_re   = s_tvalid;
            end
            S_FETCH:  mem_re = 1'b1;
            S_RESULT: out_load = !m_tvalid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Status of an arriving item, decided against the current state.
    always_comb begin
        status_in = STAT_OK;
        case (op_in)
            OP_JOIN: begin
                if ((joined_reg >= CNT_W'(MAX_PLAYERS)) || hit) status_in = STAT_FULL;
            end
            OP_ADD_TIME, OP_QUERY_PLAYER: begin
                if (!hit) status_in = STAT_UNKNOWN;
            end
            OP_TICK, OP_END_TURN, OP_QUERY_CURRENT: begin
                if (!any_player) status_in = STAT_EMPTY;
            end
            default: status_in = STAT_OK;
        endcase
    end

    // Read address: the slot to modify on accept, the slot to report later.
    always_comb begin
        if (state_reg == S_IDLE) begin
            mem_raddr = (op_in inside {OP_TICK, OP_END_TURN}) ? turn_reg : hit_slot;
        end else begin
            mem_raddr = (op_reg == OP_QUERY_PLAYER) ? slot_reg : turn_reg;
        end
    end

    // Slot update and turn bookkeeping in the modify step.
    always_comb begin
        logic [CNT_W-1:0] turn_plus;
        turn_plus    = CNT_W'(turn_reg) + CNT_W'(1);
        mem_we       = 1'b0;
        ids_we       = 1'b0;
        mem_waddr    = slot_reg;
        mem_wdata    = mem_rdata;
        joined_next  = joined_reg;
        turn_next    = turn_reg;
        running_next = running_reg;
        if (state_reg == S_MODIFY) begin
            case (op_reg)
                OP_JOIN: begin
                    if (status_reg == STAT_OK) begin
                        mem_we                 = 1'b1;
                        ids_we                 = 1'b1;
                        mem_waddr              = joined_reg[SLOT_W-1:0];
                        mem_wdata.remaining    = {1'b0, amount_reg};
                        mem_wdata.increment    = incr_reg;
                        joined_next            = joined_reg + CNT_W'(1);
                    end
                end
                OP_START: running_next = 1'b1;
                OP_STOP:  running_next = 1'b0;
                OP_TICK: begin
                    if ((status_reg == STAT_OK) && running_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = turn_reg;
                        if (mem_rdata.remaining != S32_MIN) begin
                            mem_wdata.remaining = mem_rdata.remaining - 32'sd1;
                        end
                    end
                end
                OP_END_TURN: begin
                    if (status_reg == STAT_OK) begin
                        mem_we              = 1'b1;
                        mem_waddr           = turn_reg;
                        mem_wdata.remaining = sat_add(mem_rdata.remaining,
                                                      AMOUNT_W'(mem_rdata.increment));
                        turn_next = (turn_plus >= joined_reg) ? '0 : turn_plus[SLOT_W-1:0];
                    end
                end
                OP_ADD_TIME: begin
                    if (status_reg == STAT_OK) begin
                        mem_we = 1'b1;
                        if (mem_rdata.remaining < 0) begin
                            mem_wdata.remaining = {1'b0, amount_reg};
                        end else begin
                            mem_wdata.remaining = sat_add(mem_rdata.remaining, amount_reg);
                        end
                    end
                end
                default: mem_we = 1'b0;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            joined_reg  <= '0;
            turn_reg    <= '0;
            running_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            joined_reg  <= joined_next;
            turn_reg    <= turn_next;
            running_reg <= running_next;
        end
    end

    // Item registers, loaded when an item is taken.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= op_in;
            status_reg <= status_in;
            hit_reg    <= hit;
            slot_reg   <= hit_slot;
            id_reg     <= id_in;
            amount_reg <= amount_in;
            incr_reg   <= incr_in;
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [31:0] rem_out;
        if (op_reg == OP_QUERY_PLAYER) begin
            rem_out = hit_reg ? mem_rdata.remaining : 32'sd0;
        end else begin
            rem_out = any_player ? mem_rdata.remaining : 32'sd0;
        end
        if (out_load) begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= {3'b000, 3'(joined_reg), running_reg, rem_out, any_player,
                            any_player ? turn_id : {ID_W{1'b0}}};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The turn pointer always names an occupied slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        any_player |-> (CNT_W'(turn_reg) < joined_reg))
        else $error("turn pointer beyond joined players");

    // The player count never exceeds the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        joined_reg <= CNT_W'(MAX_PLAYERS))
        else $error("player count beyond table size");

    // Slot writes happen only in the modify step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_MODIFY))
        else $error("slot write outside modify step");

    // An accepted item always moves on to the modify step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_MODIFY))
        else $error("accepted item did not start processing");

    // Turn and count change only while an item is being modified.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_MODIFY) |=> ($stable(turn_reg) && $stable(joined_reg)))
        else $error("turn state changed outside modify step");

endmodule

>>> tb/turn_clock_checker.sv
module turn_clock_checker
    import ftc_pkg::*;
#(
    parameter int SEATS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [7:0] player_id, [38:8] time_amount, [62:39] increment_amount, [63] zero
    input  logic [63:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] to_move_id, [8] to_move_valid, [40:9] remaining_time,
    // [41] is_running, [44:42] players_joined, [47:45] zero
    input  logic [47:0] m_tdata,
    // [1:0] status
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // What the clock should report after one item.
    typedef struct packed {
        status_t            status;
        logic [7:0]         mover_id;
        logic               mover_valid;
        logic signed [31:0] balance;
        logic               running;
        logic [2:0]         seated;
    } clock_report_t;

    // Shadow copy of the player table and the clock state.
    logic [7:0]         seat_id      [SEATS];
    logic signed [31:0] seat_balance [SEATS];
    logic [23:0]        seat_incr    [SEATS];
    int                 seated;
    int                 turn;
    bit                 running;

    clock_report_t expected_reports[$];
    int            mismatches;
    int            compared;

    // Clamp a wide sum to the signed 32-bit range.
    function automatic logic signed [31:0] saturate(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Slot of a joined player, or SEATS when the id is not in the table.
    function automatic int seat_of(logic [7:0] id);
        for (int i = 0; i < seated; i++) begin
            if (seat_id[i] == id) return i;
        end
        return SEATS;
    endfunction

    // Apply one item to the shadow state and build the report it should give.
    function automatic clock_report_t play_move(op_t op, logic [7:0] id,
                                                logic [30:0] amount,
                                                logic [23:0] incr);
        clock_report_t      r;
        int                 s;
        bit                 asked;
        logic signed [31:0] asked_val;
        r = '0;
        r.status = STAT_OK;
        asked = 1'b0;
        asked_val = '0;
        case (op)
            OP_JOIN: begin
                if (seated >= SEATS || seat_of(id) < SEATS) begin
                    r.status = STAT_FULL;
                end else begin
                    seat_id[seated] = id;
                    seat_balance[seated] = saturate(longint'(amount));
                    seat_incr[seated] = incr;
                    seated++;
                end
            end
            OP_START: running = 1'b1;
            OP_STOP: running = 1'b0;
            OP_TICK: begin
                if (seated == 0) begin
                    r.status = STAT_EMPTY;
                end else if (running) begin
                    seat_balance[turn] = saturate(longint'(seat_balance[turn]) - 1);
                end
            end
            OP_END_TURN: begin
                if (seated == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    seat_balance[turn] = saturate(longint'(seat_balance[turn])
                                                  + longint'(seat_incr[turn]));
                    turn++;
                    if (turn >= seated) turn = 0;
                end
            end
            OP_ADD_TIME: begin
                s = seat_of(id);
                if (s >= SEATS) begin
                    r.status = STAT_UNKNOWN;
                end else if (seat_balance[s] < 0) begin
                    // A player in deficit starts over from the added time.
                    seat_balance[s] = saturate(longint'(amount));
                end else begin
                    seat_balance[s] = saturate(longint'(seat_balance[s])
                                               + longint'(amount));
                end
            end
            OP_QUERY_PLAYER: begin
                asked = 1'b1;
                s = seat_of(id);
                if (s >= SEATS) r.status = STAT_UNKNOWN;
                else asked_val = seat_balance[s];
            end
            default: begin
                if (seated == 0) r.status = STAT_EMPTY;
            end
        endcase
        r.mover_valid = (seated > 0);
        r.mover_id = (seated > 0) ? seat_id[turn] : 8'd0;
        r.balance = asked ? asked_val : ((seated > 0) ? seat_balance[turn] : 32'sd0);
        r.running = running;
        r.seated = 3'(seated);
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare one delivered result with the oldest outstanding report.
    function automatic void compare_report(logic [47:0] data, logic [1:0] user);
        clock_report_t want;
        if (expected_reports.size() == 0) begin
            $error("result item arrived with no item outstanding");
            mismatches++;
            return;
        end
        want = expected_reports.pop_front();
        compared++;
        check_field("status", want.status, user);
        check_field("to_move_id", want.mover_id, data[7:0]);
        check_field("to_move_valid", want.mover_valid, data[8]);
        check_field("remaining_time", want.balance, longint'($signed(data[40:9])));
        check_field("is_running", want.running, data[41]);
        check_field("players_joined", want.seated, data[44:42]);
    endfunction

    // Follow both channels; every accepted item is predicted, every result checked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            seated = 0;
            turn = 0;
            running = 1'b0;
            expected_reports.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_reports.insert(expected_reports.size(),
                                        play_move(op_t'(s_tuser), s_tdata[7:0],
                                                  s_tdata[38:8], s_tdata[62:39]));
            end
            if (m_tvalid && m_tready) compare_report(m_tdata, m_tuser);
        end
        fail_count <= mismatches;
        pending_count <= expected_reports.size();
        checked_count <= compared;
    end

endmodule

>>> tb/fischer_increment_turn_clock_top_test.sv
module fischer_increment_turn_clock_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ftc_pkg::*;

    localparam int SEATS = 4;
    localparam int RANDOM_ITEMS = 850;
    // Ids that the directed part seats; random traffic mostly targets these.
    localparam logic [7:0] ROSTER [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending_count;
    int checked_count;
    bit steady;
    int sent;
    int op_tally [8];

    fischer_increment_turn_clock_top #(
        .MAX_PLAYERS(SEATS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    turn_clock_checker #(
        .SEATS(SEATS)
    ) checker_i (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .fail_count(fail_count),
        .pending_count(pending_count),
        .checked_count(checked_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_item(op_t op, logic [7:0] id, logic [30:0] amount,
                             logic [23:0] incr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, incr, amount, id};
        do @(posedge aclk); while (!s_tready);
        op_tally[int'(op)]++;
        sent++;
    endtask

    // Result side: stall a random number of cycles before each result.
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Stimulus and verdict.
    initial begin
        int          roll;
        int          pick;
        op_t         op;
        logic [7:0]  id;
        logic [30:0] amount;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_JOIN;
        steady <= 1'b0;
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table: everything that needs a player reports so.
        send_item(OP_TICK, 8'h00, '0, '0);
        send_item(OP_END_TURN, 8'h00, '0, '0);
        send_item(OP_QUERY_CURRENT, 8'h00, '0, '0);
        send_item(OP_QUERY_PLAYER, 8'h33, '0, '0);
        send_item(OP_ADD_TIME, 8'h33, 31'd5, '0);
        send_item(OP_START, 8'h00, '0, '0);
        send_item(OP_TICK, 8'h00, '0, '0);
        send_item(OP_STOP, 8'h00, '0, '0);
        // Extreme players, then a duplicate id.
        send_item(OP_JOIN, 8'h00, 31'd0, 24'd0);
        send_item(OP_JOIN, 8'hFF, 31'h7FFF_FFFF, 24'hFF_FFFF);
        send_item(OP_JOIN, 8'hFF, 31'd9, 24'd1);
        // Drive the first player into deficit, then refill it.
        send_item(OP_START, 8'h00, '0, '0);
        send_item(OP_TICK, 8'h00, '0, '0);
        send_item(OP_TICK, 8'h00, '0, '0);
        send_item(OP_QUERY_PLAYER, 8'h00, '0, '0);
        send_item(OP_ADD_TIME, 8'h00, 31'd7, '0);
        // Turn passing, increment saturation and add-time saturation.
        send_item(OP_END_TURN, 8'h00, '0, '0);
        send_item(OP_END_TURN, 8'h00, '0, '0);
        send_item(OP_ADD_TIME, 8'hFF, 31'h7FFF_FFFF, '0);
        // Join while running, fill the table, then overfill it.
        send_item(OP_JOIN, 8'h5A, 31'd3, 24'd2);
        send_item(OP_JOIN, 8'hA5, 31'h2AAA_AAAA, 24'h55_5555);
        send_item(OP_JOIN, 8'h11, 31'h5555_5555, 24'hAA_AAAA);
        send_item(OP_STOP, 8'h00, '0, '0);
        send_item(OP_TICK, 8'h00, '0, '0);
        send_item(OP_QUERY_CURRENT, 8'h00, '0, '0);

        // Random game traffic: mostly ticks and turn ends on seated players.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) steady <= ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 40) op = OP_TICK;
            else if (roll < 55) op = OP_END_TURN;
            else if (roll < 65) op = OP_ADD_TIME;
            else if (roll < 75) op = OP_QUERY_PLAYER;
            else if (roll < 81) op = OP_QUERY_CURRENT;
            else if (roll < 86) op = OP_START;
            else if (roll < 90) op = OP_STOP;
            else op = OP_JOIN;
            id = ($urandom_range(0, 3) != 0) ? ROSTER[$urandom_range(0, 3)]
                                              : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            if (pick < 6) amount = 31'($urandom_range(0, 40));
            else if (pick < 9) amount = 31'($urandom_range(0, 5000));
            else amount = 31'($urandom());
            send_item(op, id, amount, 24'($urandom()));
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then allow the pipeline to settle.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d items: %0d joins, %0d starts, %0d stops, %0d ticks, %0d turn ends,",
                 sent, op_tally[OP_JOIN], op_tally[OP_START], op_tally[OP_STOP],
                 op_tally[OP_TICK], op_tally[OP_END_TURN]);
        $display("%0d time adds, %0d player and %0d current queries; %0d results compared.",
                 op_tally[OP_ADD_TIME], op_tally[OP_QUERY_PLAYER],
                 op_tally[OP_QUERY_CURRENT], checked_count);
        if (fail_count == 0) begin
            $display("fischer_increment_turn_clock_top_test OK");
        end else begin
            $display("fischer_increment_turn_clock_top_test NOT OK");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("fischer_increment_turn_clock_top_test NOT OK");
        $finish;
    end

endmodule
